FILE: design/mps_pkg.sv
// Shared types, constants and helper functions of the streaming max pooling block.
`default_nettype none
package mps_pkg;
  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 8;
  localparam int IDX_W      = 9;
  localparam int CRD_W      = 11;
  localparam int KER        = 8;
  localparam int SLOT_W     = 3;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;
  localparam int MEM_AW     = SLOT_W + IDX_W;
  localparam int MEM_DEPTH  = 1 << MEM_AW;
  localparam int MAX_DIM    = 256;

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_WRITE} state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH    = 4'd0,
    REG_IN_HEIGHT   = 4'd1,
    REG_WIN_ROWS    = 4'd2,
    REG_WIN_COLS    = 4'd3,
    REG_STEP_ROWS   = 4'd4,
    REG_STEP_COLS   = 4'd5,
    REG_MARGIN_ROWS = 4'd6,
    REG_MARGIN_COLS = 4'd7
  } reg_idx_t;

  function automatic crd_t to_crd(input logic [9:0] x);
    return crd_t'({1'b0, x});
  endfunction

  function automatic logic [8:0] clamp_dim(input logic [8:0] v);
    if (v == 9'd0) return 9'd1;
    if (v > 9'(MAX_DIM)) return 9'(MAX_DIM);
    return v;
  endfunction

  function automatic logic [3:0] clamp_ker(input logic [3:0] v);
    if (v == 4'd0) return 4'd1;
    if (v > 4'(KER)) return 4'(KER);
    return v;
  endfunction

  function automatic logic [2:0] clamp_pad(input logic [2:0] m, input logic [3:0] k);
    if ({1'b0, m} > k - 4'd1) return 3'(k - 4'd1);
    return m;
  endfunction

  // Number of whole strides that fit into the leading padding.
  function automatic logic [3:0] first_count(input logic [2:0] pad, input logic [3:0] step);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 1; k < KER; k++) begin
      if (7'(k) * {3'b0, step} <= {4'b0, pad}) n = n + 4'd1;
    end
    return n;
  endfunction
endpackage
`default_nettype wire

FILE: design/max_pool2d_stream.sv
// Top level of the streaming 2-D max pooling block.
// A pixel that completes no window is taken in the idle state alone; each window partial it
// updates adds a column memory read state, then a modify and write-back state.
// Throughput: one pixel per cycle away from window ends; no new pixel enters during updates.
// Output register decouples the result channel; the next pixel enters while it waits.
// Synchronous active-low reset: registers 1, 1, 1, 1, 1, 1, 0, 0; position at zero.
`default_nettype none
module max_pool2d_stream (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [mps_pkg::SAMPLE_W-1:0]     in_sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [mps_pkg::SAMPLE_W-1:0]     out_pooled,
  output logic        [mps_pkg::IDX_W-1:0]        out_row,
  output logic        [mps_pkg::IDX_W-1:0]        out_col,
  output logic                                    out_item_last,
  output logic                                    out_plane_done,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [mps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic        [mps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mps_pkg::*;

  logic [8:0] in_width_r, in_height_r;
  logic [3:0] win_rows_r, win_cols_r, step_rows_r, step_cols_r;
  logic [2:0] margin_rows_r, margin_cols_r;

  logic [8:0] w_eff, h_eff;
  logic [3:0] kh, kw, sh, sw;
  logic [2:0] ph, pw;
  crd_t wlim, hlim, wm1, hm1, kwm1, khm1;

  logic [POS_W-1:0] col_r, row_r;
  logic [IDX_W-1:0] clo_ow_r, chi_ow_r, rlo_ow_r, rhi_ow_r;
  crd_t clo_st_r, chi_st_r, rlo_st_r, rhi_st_r;
  logic [IDX_W-1:0] cur_clo_ow, cur_chi_ow, cur_rlo_ow, cur_rhi_ow;
  crd_t cur_clo_st, cur_chi_st, cur_rlo_st, cur_rhi_st;
  crd_t init_chi_st, init_rhi_st;
  logic [3:0] q0c, q0r;
  crd_t c_crd, r_crd;

  logic [IDX_W-1:0] ow_v [KER];
  crd_t st_v [KER];
  logic [KER-1:0] vld_c, hit_c;
  logic [KER-1:0] rvld, remit;
  logic [CNT_W-1:0] ns_acc, nr_acc, ne_acc;

  logic signed [SAMPLE_W-1:0] rp_r [KER];
  logic signed [SAMPLE_W-1:0] rp_nxt [KER];
  logic [KER-1:0] rp_wen;

  logic signed [SAMPLE_W-1:0] colmem [MEM_DEPTH];
  logic signed [SAMPLE_W-1:0] memq_r;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] b_ow_r, b_oh_r;
  crd_t b_st_r, b_rs_r, rq_r;
  logic [CNT_W-1:0] ns_r, nr_r, ne_r;
  logic [SLOT_W-1:0] i_r, j_r;

  logic [IDX_W-1:0] ow_cur, oh_cur;
  crd_t rs_cur, cs_cur, rfirst_cur;
  logic emit, row_first, end_i, end_j, ow_last, oh_last, last_item;
  logic signed [SAMPLE_W-1:0] h_cur, new_val;
  logic [MEM_AW-1:0] mem_addr;
  logic accept, cfg_hit, mem_re, mem_we, out_load, stall;

  logic signed [SAMPLE_W-1:0] pooled_r;
  logic [IDX_W-1:0] orow_r, ocol_r;
  logic out_valid_r, ilast_r, pdone_r;

  always_comb begin
    w_eff = clamp_dim(in_width_r);
    h_eff = clamp_dim(in_height_r);
    kh    = clamp_ker(win_rows_r);
    kw    = clamp_ker(win_cols_r);
    sh    = clamp_ker(step_rows_r);
    sw    = clamp_ker(step_cols_r);
    ph    = clamp_pad(margin_rows_r, kh);
    pw    = clamp_pad(margin_cols_r, kw);
    wm1   = to_crd(10'(w_eff)) - crd_t'(1);
    hm1   = to_crd(10'(h_eff)) - crd_t'(1);
    wlim  = wm1 + to_crd(10'(pw));
    hlim  = hm1 + to_crd(10'(ph));
    kwm1  = to_crd(10'(kw)) - crd_t'(1);
    khm1  = to_crd(10'(kh)) - crd_t'(1);
    q0c   = first_count(pw, sw);
    q0r   = first_count(ph, sh);
    init_chi_st = to_crd(10'(q0c)) * to_crd(10'(sw)) - to_crd(10'(pw));
    init_rhi_st = to_crd(10'(q0r)) * to_crd(10'(sh)) - to_crd(10'(ph));
    c_crd = to_crd(10'(col_r));
    r_crd = to_crd(10'(row_r));
  end

  always_comb begin
    if (col_r == '0) begin
      cur_clo_ow = '0;
      cur_clo_st = -to_crd(10'(pw));
      cur_chi_ow = 9'(q0c);
      cur_chi_st = init_chi_st;
    end else begin
      cur_clo_ow = clo_ow_r;
      cur_clo_st = clo_st_r;
      cur_chi_ow = chi_ow_r;
      cur_chi_st = chi_st_r;
    end
    if (row_r == '0) begin
      cur_rlo_ow = '0;
      cur_rlo_st = -to_crd(10'(ph));
      cur_rhi_ow = 9'(q0r);
      cur_rhi_st = init_rhi_st;
    end else begin
      cur_rlo_ow = rlo_ow_r;
      cur_rlo_st = rlo_st_r;
      cur_rhi_ow = rhi_ow_r;
      cur_rhi_st = rhi_st_r;
    end
  end

  always_comb begin
    crd_t e, lst, rs, re;
    logic [IDX_W-1:0] oh;
    ns_acc = '0;
    nr_acc = '0;
    ne_acc = '0;
    for (int i = 0; i < KER; i++) begin
      ow_v[i]  = cur_clo_ow + 9'(i);
      st_v[i]  = cur_clo_st + crd_t'(i) * to_crd(10'(sw));
      e        = st_v[i] + kwm1;
      lst      = (e < wm1) ? e : wm1;
      vld_c[i] = (ow_v[i] <= cur_chi_ow) && (e <= wlim);
      hit_c[i] = vld_c[i] && (lst == c_crd);
      if (hit_c[i]) ns_acc = ns_acc + 4'd1;
      oh       = cur_rlo_ow + 9'(i);
      rs       = cur_rlo_st + crd_t'(i) * to_crd(10'(sh));
      re       = rs + khm1;
      rvld[i]  = (oh <= cur_rhi_ow) && (re <= hlim);
      remit[i] = rvld[i] && (((re < hm1) ? re : hm1) == r_crd);
      if (rvld[i]) nr_acc = nr_acc + 4'd1;
      if (remit[i]) ne_acc = ne_acc + 4'd1;
    end
  end

  always_comb begin
    logic [SLOT_W-1:0] k;
    crd_t first;
    for (int s = 0; s < KER; s++) begin
      k         = 3'(s) - cur_clo_ow[SLOT_W-1:0];
      first     = (st_v[k] < crd_t'(0)) ? crd_t'(0) : st_v[k];
      rp_wen[s] = accept && vld_c[k];
      if (c_crd == first) rp_nxt[s] = in_sample;
      else rp_nxt[s] = (rp_r[s] > in_sample) ? rp_r[s] : in_sample;
    end
  end

  always_comb begin
    ow_cur     = b_ow_r + 9'(i_r);
    oh_cur     = b_oh_r + 9'(j_r);
    rs_cur     = b_rs_r + to_crd(10'(j_r)) * to_crd(10'(sh));
    cs_cur     = b_st_r + to_crd(10'(i_r)) * to_crd(10'(sw));
    rfirst_cur = (rs_cur < crd_t'(0)) ? crd_t'(0) : rs_cur;
    row_first  = (rq_r == rfirst_cur);
    emit       = {1'b0, j_r} < ne_r;
    end_i      = {1'b0, i_r} == ns_r - 4'd1;
    end_j      = {1'b0, j_r} == nr_r - 4'd1;
    last_item  = end_i && ({1'b0, j_r} == ne_r - 4'd1);
    ow_last    = cs_cur + kwm1 + to_crd(10'(sw)) > wlim;
    oh_last    = rs_cur + khm1 + to_crd(10'(sh)) > hlim;
    h_cur      = rp_r[ow_cur[SLOT_W-1:0]];
    new_val    = (row_first || h_cur > memq_r) ? h_cur : memq_r;
    mem_addr   = {oh_cur[SLOT_W-1:0], ow_cur};
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept && ns_acc != '0 && nr_acc != '0) state_nxt = ST_READ;
        else state_nxt = ST_IDLE;
      end
      ST_READ:  state_nxt = ST_WRITE;
      ST_WRITE: begin
        if (stall) state_nxt = ST_WRITE;
        else if (end_i && end_j) state_nxt = ST_IDLE;
        else state_nxt = ST_READ;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    mem_re   = (state_r == ST_READ);
    stall    = (state_r == ST_WRITE) && emit && out_valid_r && !out_ready;
    mem_we   = (state_r == ST_WRITE) && !stall;
    out_load = mem_we && emit;
  end

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index <= REG_MARGIN_COLS);

  always_ff @(posedge clk) begin
    if (mem_we) colmem[mem_addr] <= new_val;
    if (mem_re) memq_r <= colmem[mem_addr];
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < KER; s++) begin
      if (rp_wen[s]) rp_r[s] <= rp_nxt[s];
    end
    if (accept) begin
      b_ow_r <= cur_clo_ow;
      b_st_r <= cur_clo_st;
      b_oh_r <= cur_rlo_ow;
      b_rs_r <= cur_rlo_st;
      rq_r   <= r_crd;
      ns_r   <= ns_acc;
      nr_r   <= nr_acc;
      ne_r   <= ne_acc;
      if (cur_clo_st + kwm1 < c_crd + crd_t'(1)) begin
        clo_ow_r <= cur_clo_ow + 9'd1;
        clo_st_r <= cur_clo_st + to_crd(10'(sw));
      end else begin
        clo_ow_r <= cur_clo_ow;
        clo_st_r <= cur_clo_st;
      end
      if (cur_chi_st + to_crd(10'(sw)) <= c_crd + crd_t'(1)) begin
        chi_ow_r <= cur_chi_ow + 9'd1;
        chi_st_r <= cur_chi_st + to_crd(10'(sw));
      end else begin
        chi_ow_r <= cur_chi_ow;
        chi_st_r <= cur_chi_st;
      end
      if ({1'b0, col_r} == w_eff - 9'd1) begin
        if (cur_rlo_st + khm1 < r_crd + crd_t'(1)) begin
          rlo_ow_r <= cur_rlo_ow + 9'd1;
          rlo_st_r <= cur_rlo_st + to_crd(10'(sh));
        end else begin
          rlo_ow_r <= cur_rlo_ow;
          rlo_st_r <= cur_rlo_st;
        end
        if (cur_rhi_st + to_crd(10'(sh)) <= r_crd + crd_t'(1)) begin
          rhi_ow_r <= cur_rhi_ow + 9'd1;
          rhi_st_r <= cur_rhi_st + to_crd(10'(sh));
        end else begin
          rhi_ow_r <= cur_rhi_ow;
          rhi_st_r <= cur_rhi_st;
        end
      end
    end
    if (out_load) begin
      pooled_r <= new_val;
      orow_r   <= oh_cur;
      ocol_r   <= ow_cur;
      ilast_r  <= last_item;
      pdone_r  <= ow_last && oh_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r    <= 9'd1;
      in_height_r   <= 9'd1;
      win_rows_r    <= 4'd1;
      win_cols_r    <= 4'd1;
      step_rows_r   <= 4'd1;
      step_cols_r   <= 4'd1;
      margin_rows_r <= 3'd0;
      margin_cols_r <= 3'd0;
      col_r         <= '0;
      row_r         <= '0;
      state_r       <= ST_IDLE;
      i_r           <= '0;
      j_r           <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_IN_WIDTH:    in_width_r    <= cfg_data;
          REG_IN_HEIGHT:   in_height_r   <= cfg_data;
          REG_WIN_ROWS:    win_rows_r    <= cfg_data[3:0];
          REG_WIN_COLS:    win_cols_r    <= cfg_data[3:0];
          REG_STEP_ROWS:   step_rows_r   <= cfg_data[3:0];
          REG_STEP_COLS:   step_cols_r   <= cfg_data[3:0];
          REG_MARGIN_ROWS: margin_rows_r <= cfg_data[2:0];
          REG_MARGIN_COLS: margin_cols_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        if ({1'b0, col_r} == w_eff - 9'd1) begin
          col_r <= '0;
          if ({1'b0, row_r} == h_eff - 9'd1) row_r <= '0;
          else row_r <= row_r + 8'd1;
        end else begin
          col_r <= col_r + 8'd1;
        end
      end
      if (accept) begin
        i_r <= '0;
        j_r <= '0;
      end else if (mem_we) begin
        if (end_i) begin
          i_r <= '0;
          j_r <= j_r + 3'd1;
        end else begin
          i_r <= i_r + 3'd1;
        end
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pooled     = pooled_r;
  assign out_row        = orow_r;
  assign out_col        = ocol_r;
  assign out_item_last  = ilast_r;
  assign out_plane_done = pdone_r;
endmodule
`default_nettype wire

FILE: design/mps_checker.sv
// Port-level checker of the max pooling block and its bind to the top level.
`default_nettype none
module mps_checker (
  input wire                                    clk,
  input wire                                    rst_n,
  input wire                                    in_valid,
  input wire                                    in_ready,
  input wire signed [mps_pkg::SAMPLE_W-1:0]     in_sample,
  input wire                                    out_valid,
  input wire                                    out_ready,
  input wire signed [mps_pkg::SAMPLE_W-1:0]     out_pooled,
  input wire        [mps_pkg::IDX_W-1:0]        out_row,
  input wire        [mps_pkg::IDX_W-1:0]        out_col,
  input wire                                    out_item_last,
  input wire                                    out_plane_done,
  input wire                                    cfg_valid,
  input wire                                    cfg_ready,
  input wire        [mps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input wire        [mps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mps_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pooled) && $stable(out_row) && $stable(out_col))
    else $error("stalled result item changed");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_plane_done |-> out_item_last)
    else $error("plane end is not the last result of its item");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item_last |-> !in_ready)
    else $error("new item taken while results of the previous one are pending");
endmodule

bind max_pool2d_stream mps_checker u_mps_checker (.*);
`default_nettype wire
